### src/rrqs_pkg.sv
// package for the round robin quantum scheduler: constants and helpers
`default_nettype none
package rrqs_pkg;
    localparam int SLOTS_DEF = 16;
    localparam logic [15:0] FIRST_Q_RESET = 16'd10;

    localparam logic [2:0] K_TICK    = 3'd0;
    localparam logic [2:0] K_ALLOC   = 3'd1;
    localparam logic [2:0] K_RELEASE = 3'd2;
    localparam logic [2:0] K_BLOCK   = 3'd3;
    localparam logic [2:0] K_UNBLOCK = 3'd4;
    localparam logic [2:0] K_FIND    = 3'd5;

    localparam logic [1:0] M_FREE  = 2'd0;
    localparam logic [1:0] M_READY = 2'd1;
    localparam logic [1:0] M_RUN   = 2'd2;
    localparam logic [1:0] M_BLOCK = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_NO_PID   = 2'd2;
    localparam logic [1:0] ST_NOT_LIVE = 2'd3;

    function automatic logic [15:0] clamp_q(input logic [15:0] q);
        clamp_q = (q == 16'd0) ? 16'd1 : q;
    endfunction
endpackage
`default_nettype wire

### src/rrqs_slot_mem.sv
// per-slot record memory: pid, quantum, ticks, switches, remaining, mode
`default_nettype none
module rrqs_slot_mem
    import rrqs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int SW = $clog2(SLOTS),
    localparam int RW = 15 + 16 + 32 + 32 + 16 + 2
) (
    input  wire logic          i_clk,
    input  wire logic [SW-1:0] i_raddr,
    output logic      [RW-1:0] o_rdata,
    input  wire logic          i_we,
    input  wire logic [SW-1:0] i_waddr,
    input  wire logic [RW-1:0] i_wdata
);
    logic [RW-1:0] r_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/rrqs_link_mem.sv
// link memory: ready next, ready prev and free link per slot
`default_nettype none
module rrqs_link_mem
    import rrqs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int SW = $clog2(SLOTS),
    localparam int LW = 3 * (SW + 1)
) (
    input  wire logic          i_clk,
    input  wire logic [SW-1:0] i_raddr,
    output logic      [LW-1:0] o_rdata,
    input  wire logic          i_we,
    input  wire logic [SW-1:0] i_waddr,
    input  wire logic [LW-1:0] i_wdata
);
    logic [LW-1:0] r_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/round_robin_quantum_scheduler.sv
// round robin quantum scheduler top level: sequencer over slot and link memories
//
// channel   dir  handshake        payload
// request   in   i_valid/o_stall  i_kind i_slot i_pid i_task_quantum
// result    out  o_valid/i_stall  o_switched o_running_slot o_slot_out o_status
//                                 o_ticks_used o_switch_count o_quantum_left
// config    in   i_cfg_valid/o_cfg_ready  i_cfg_data
//
// a request does one memory read-modify-write per touched slot, each read is registered;
// find reads the entries in order until a live entry matches the pid or the last is read
// after reset an init pass writes every entry, no request accepted then
// a finished result waits in the output register; the next request is taken meanwhile
// config writes are accepted only while no request is in progress
`default_nettype none
module round_robin_quantum_scheduler
    import rrqs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [3:0]  i_slot,
    input  wire logic [14:0] i_pid,
    input  wire logic [15:0] i_task_quantum,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_switched,
    output logic [3:0]       o_running_slot,
    output logic [3:0]       o_slot_out,
    output logic [1:0]       o_status,
    output logic [31:0]      o_ticks_used,
    output logic [31:0]      o_switch_count,
    output logic [15:0]      o_quantum_left,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    localparam int SW = $clog2(SLOTS);
    localparam int PW = SW + 1;
    localparam int RW = 15 + 16 + 32 + 32 + 16 + 2;
    localparam int LW = 3 * PW;
    localparam logic [PW-1:0] NIL = PW'(SLOTS);
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    typedef struct packed {
        logic [14:0] pid;
        logic [15:0] quantum;
        logic [31:0] ticks;
        logic [31:0] switches;
        logic [15:0] remaining;
        logic [1:0]  mode;
    } t_slot;

    typedef struct packed {
        logic [PW-1:0] next;
        logic [PW-1:0] prev;
        logic [PW-1:0] free;
    } t_link;

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_RD     = 5'd2;
    localparam logic [4:0] S_EXEC   = 5'd3;
    localparam logic [4:0] S_UL_P   = 5'd4;
    localparam logic [4:0] S_UL_PW  = 5'd5;
    localparam logic [4:0] S_UL_N   = 5'd6;
    localparam logic [4:0] S_UL_NW  = 5'd7;
    localparam logic [4:0] S_AP_T   = 5'd8;
    localparam logic [4:0] S_AP_TW  = 5'd9;
    localparam logic [4:0] S_AP_S   = 5'd10;
    localparam logic [4:0] S_AP_SW  = 5'd11;
    localparam logic [4:0] S_POST   = 5'd12;
    localparam logic [4:0] S_DS     = 5'd13;
    localparam logic [4:0] S_DSW    = 5'd14;
    localparam logic [4:0] S_FIND   = 5'd15;
    localparam logic [4:0] S_FINDW  = 5'd16;
    localparam logic [4:0] S_CUR    = 5'd17;
    localparam logic [4:0] S_CURW   = 5'd18;
    localparam logic [4:0] S_OUT    = 5'd19;
    localparam logic [4:0] S_CFG    = 5'd20;
    localparam logic [4:0] S_CFGW   = 5'd21;
    localparam logic [4:0] S_TICKW  = 5'd22;

    // post-unlink actions
    localparam logic [2:0] P_NONE    = 3'd0;
    localparam logic [2:0] P_ROTATE  = 3'd1;
    localparam logic [2:0] P_RELEASE = 3'd2;
    localparam logic [2:0] P_BLOCK   = 3'd3;
    localparam logic [2:0] P_APPEND  = 3'd4;

    logic [4:0]    r_state, n_state;
    logic [2:0]    r_post, n_post;
    logic [PW-1:0] r_head, n_head, r_tail, n_tail, r_ftop, n_ftop;
    logic [SW-1:0] r_cur, n_cur;
    logic [15:0]   r_round, n_round;
    logic [15:0]   r_fq, n_fq;
    logic [2:0]    r_kind, n_kind;
    logic [SW-1:0] r_s, n_s;
    logic          r_s_ok, n_s_ok;
    logic [14:0]   r_pid, n_pid;
    logic [15:0]   r_tq, n_tq;
    logic [SW-1:0] r_ptr, n_ptr;
    logic [PW-1:0] r_up, n_up, r_un, n_un;
    logic          r_dispatch, n_dispatch;
    logic          r_sw, n_sw;
    logic [3:0]    r_sout, n_sout;
    logic [1:0]    r_st, n_st;
    logic [31:0]   r_tk, n_tk, r_cnt, n_cnt;
    logic [15:0]   r_ql, n_ql;
    logic          r_ov, n_ov;
    logic [3:0]    r_orun, n_orun;
    logic          r_osw, n_osw;
    logic [3:0]    r_osout, n_osout;
    logic [1:0]    r_ost, n_ost;
    logic [31:0]   r_otk, n_otk, r_ocnt, n_ocnt;

    logic [SW-1:0] s_raddr, l_raddr, s_waddr, l_waddr;
    logic          s_we, l_we;
    t_slot         s_rd, s_wd;
    t_link         l_rd, l_wd;

    rrqs_slot_mem #(.SLOTS(SLOTS)) u_slot (
        .i_clk(i_clk), .i_raddr(s_raddr), .o_rdata(s_rd),
        .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wd)
    );
    rrqs_link_mem #(.SLOTS(SLOTS)) u_link (
        .i_clk(i_clk), .i_raddr(l_raddr), .o_rdata(l_rd),
        .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wd)
    );

    logic out_free;
    assign out_free = !r_ov || !i_stall;
    assign o_stall = !(r_state == S_IDLE && !i_cfg_valid);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_switched = r_osw;
    assign o_running_slot = r_orun;
    assign o_slot_out = r_osout;
    assign o_status = r_ost;
    assign o_ticks_used = r_otk;
    assign o_switch_count = r_ocnt;
    assign o_quantum_left = r_ql;

    always_comb begin
        n_state = r_state; n_post = r_post; n_head = r_head; n_tail = r_tail;
        n_ftop = r_ftop; n_cur = r_cur; n_round = r_round; n_fq = r_fq;
        n_kind = r_kind; n_s = r_s; n_s_ok = r_s_ok; n_pid = r_pid; n_tq = r_tq;
        n_ptr = r_ptr; n_up = r_up; n_un = r_un; n_dispatch = r_dispatch;
        n_sw = r_sw; n_sout = r_sout; n_st = r_st; n_tk = r_tk; n_cnt = r_cnt;
        n_ql = r_ql; n_ov = r_ov; n_orun = r_orun;
        n_osw = r_osw; n_osout = r_osout; n_ost = r_ost; n_otk = r_otk; n_ocnt = r_ocnt;
        s_raddr = r_ptr; l_raddr = r_ptr; s_waddr = r_ptr; l_waddr = r_ptr;
        s_we = 1'b0; l_we = 1'b0; s_wd = s_rd; l_wd = l_rd;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_INIT: begin
                s_we = 1'b1; l_we = 1'b1;
                s_wd = '0;
                l_wd.next = NIL; l_wd.prev = NIL;
                l_wd.free = (r_ptr <= SW'(1)) ? NIL : PW'(r_ptr) - PW'(1);
                if (r_ptr == '0) begin
                    s_wd.quantum = FIRST_Q_RESET;
                    s_wd.remaining = FIRST_Q_RESET;
                    s_wd.mode = M_RUN;
                end
                n_ptr = r_ptr + SW'(1);
                if (r_ptr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_fq = clamp_q(i_cfg_data);
                    n_ptr = '0;
                    n_state = S_CFG;
                end else if (i_valid) begin
                    n_kind = i_kind;
                    n_s = SW'(i_slot);
                    n_s_ok = ({1'b0, i_slot} < 5'(SLOTS));
                    n_pid = i_pid;
                    n_tq = clamp_q(i_task_quantum);
                    n_sw = 1'b0; n_sout = '0; n_st = ST_OK; n_tk = '0; n_cnt = '0;
                    n_post = P_NONE; n_dispatch = 1'b0;
                    unique case (i_kind)
                        K_TICK: n_ptr = r_cur;
                        K_ALLOC: n_ptr = r_ftop[SW-1:0];
                        K_FIND: n_ptr = '0;
                        default: n_ptr = SW'(i_slot);
                    endcase
                    n_state = S_RD;
                end
            end
            S_CFG: n_state = S_CFGW;
            S_CFGW: begin
                s_we = 1'b1;
                s_wd.quantum = r_fq;
                if (r_cur == '0) begin
                    s_wd.remaining = r_fq;
                    n_round = r_fq;
                end
                n_state = S_IDLE;
            end
            S_RD: begin
                if (r_kind == K_FIND) begin
                    n_state = S_FINDW;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_FIND: n_state = S_FINDW;
            S_FINDW: begin
                if (s_rd.mode != M_FREE && s_rd.pid == r_pid) begin
                    n_sout = 4'(r_ptr);
                    n_tk = s_rd.ticks;
                    n_cnt = s_rd.switches;
                    n_state = S_CUR;
                    n_ptr = r_cur;
                end else if (r_ptr == LAST) begin
                    n_st = ST_NO_PID;
                    n_state = S_CUR;
                    n_ptr = r_cur;
                end else begin
                    n_ptr = r_ptr + SW'(1);
                    n_state = S_FIND;
                end
            end
            S_EXEC: begin
                n_up = l_rd.prev; n_un = l_rd.next;
                n_state = S_CUR;
                n_ptr = r_cur;
                priority case (r_kind)
                    K_TICK: begin
                        s_we = 1'b1;
                        s_wd.ticks = s_rd.ticks + 32'd1;
                        if (s_rd.remaining != '0) begin
                            s_wd.remaining = s_rd.remaining - 16'd1;
                        end
                        if (r_round > 16'd1) begin
                            n_round = r_round - 16'd1;
                        end else begin
                            n_round = clamp_q(s_rd.quantum);
                            n_dispatch = 1'b1;
                            if (s_rd.mode == M_READY || s_rd.mode == M_RUN) begin
                                s_wd.mode = M_READY;
                                n_s = r_cur;
                                n_post = P_ROTATE;
                                n_state = S_UL_P;
                            end else begin
                                n_state = S_POST;
                            end
                        end
                    end
                    K_ALLOC: begin
                        if (r_ftop == NIL) begin
                            n_st = ST_NO_FREE;
                        end else begin
                            s_we = 1'b1; l_we = 1'b1;
                            s_wd.pid = r_pid; s_wd.quantum = r_tq; s_wd.ticks = '0;
                            s_wd.switches = '0; s_wd.remaining = r_tq; s_wd.mode = M_READY;
                            n_ftop = l_rd.free;
                            l_wd.free = NIL; l_wd.prev = r_tail; l_wd.next = NIL;
                            n_sout = 4'(r_ptr);
                            n_s = r_ptr;
                            n_post = P_APPEND;
                            n_state = S_AP_T;
                        end
                    end
                    K_RELEASE, K_BLOCK, K_UNBLOCK: begin
                        if (!r_s_ok || s_rd.mode == M_FREE) begin
                            n_st = ST_NOT_LIVE;
                        end else if (r_kind == K_RELEASE) begin
                            s_we = 1'b1; l_we = 1'b1;
                            s_wd.pid = '0; s_wd.mode = M_FREE;
                            l_wd.free = r_ftop;
                            n_ftop = PW'(r_ptr);
                            if (s_rd.mode == M_READY || s_rd.mode == M_RUN) begin
                                n_state = S_UL_P;
                            end
                        end else if (r_kind == K_BLOCK) begin
                            if (s_rd.mode == M_READY || s_rd.mode == M_RUN) begin
                                s_we = 1'b1; s_wd.mode = M_BLOCK;
                                n_state = S_UL_P;
                            end
                        end else if (r_kind == K_UNBLOCK) begin
                            if (s_rd.mode == M_BLOCK) begin
                                s_we = 1'b1; l_we = 1'b1;
                                s_wd.mode = M_READY;
                                l_wd.prev = r_tail; l_wd.next = NIL;
                                n_post = P_APPEND;
                                n_state = S_AP_T;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // unlink r_s: fix prev's next, then next's prev, then clear own links
            S_UL_P: begin
                if (r_up == NIL) begin
                    n_head = r_un;
                    n_state = S_UL_N;
                end else begin
                    n_ptr = r_up[SW-1:0];
                    n_state = S_UL_PW;
                end
                l_raddr = n_ptr;
            end
            S_UL_PW: begin
                l_we = 1'b1; l_wd.next = r_un;
                n_state = S_UL_N;
            end
            S_UL_N: begin
                if (r_un == NIL) begin
                    n_tail = r_up;
                    n_ptr = r_s;
                    n_state = S_AP_S;
                end else begin
                    n_ptr = r_un[SW-1:0];
                    n_state = S_UL_NW;
                end
                l_raddr = n_ptr;
            end
            S_UL_NW: begin
                l_we = 1'b1; l_wd.prev = r_up;
                n_ptr = r_s;
                n_state = S_AP_S;
            end
            S_AP_S: n_state = S_AP_SW;
            S_AP_SW: begin
                // own links cleared, or set as new tail on rotate
                l_we = 1'b1; l_wd.next = NIL;
                if (r_post == P_ROTATE) begin
                    l_wd.prev = r_tail;
                    if (r_tail == NIL) begin
                        n_head = PW'(r_s);
                    end
                    n_post = P_APPEND;
                    if (r_tail != NIL) begin
                        n_ptr = r_tail[SW-1:0];
                        n_state = S_AP_TW;
                        n_tail = PW'(r_s);
                    end else begin
                        n_tail = PW'(r_s);
                        n_state = S_POST;
                    end
                end else begin
                    l_wd.prev = NIL;
                    n_state = S_POST;
                end
                l_raddr = n_ptr;
            end
            // append r_s after current tail (own links already written)
            S_AP_T: begin
                if (r_tail == NIL) begin
                    n_head = PW'(r_s);
                    n_tail = PW'(r_s);
                    n_state = S_POST;
                end else begin
                    n_ptr = r_tail[SW-1:0];
                    n_tail = PW'(r_s);
                    n_state = S_AP_TW;
                end
                l_raddr = n_ptr;
            end
            S_AP_TW: begin
                l_we = 1'b1; l_wd.next = PW'(r_s);
                n_state = S_POST;
            end
            S_POST: begin
                if (r_dispatch && r_head != NIL) begin
                    n_ptr = r_head[SW-1:0];
                    n_state = S_DS;
                end else begin
                    n_ptr = r_cur;
                    n_state = S_CUR;
                end
            end
            S_DS: n_state = S_DSW;
            S_DSW: begin
                s_we = 1'b1;
                s_wd.switches = s_rd.switches + 32'd1;
                s_wd.remaining = clamp_q(s_rd.quantum);
                s_wd.mode = M_RUN;
                n_round = clamp_q(s_rd.quantum);
                n_cur = r_ptr;
                n_sw = 1'b1;
                n_state = S_CUR;
            end
            S_CUR: n_state = S_CURW;
            S_CURW: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ql = s_rd.remaining;
                    n_orun = 4'(r_cur);
                    n_osw = r_sw;
                    n_osout = r_sout;
                    n_ost = r_st;
                    n_otk = r_tk;
                    n_ocnt = r_cnt;
                    n_state = S_IDLE;
                end
            end
            S_TICKW: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_post <= P_NONE; r_head <= '0; r_tail <= '0;
            r_ftop <= PW'(LAST); r_cur <= '0; r_round <= FIRST_Q_RESET;
            r_ptr <= '0; r_ov <= 1'b0; r_dispatch <= 1'b0; r_fq <= FIRST_Q_RESET;
        end else begin
            r_state <= n_state; r_post <= n_post; r_head <= n_head; r_tail <= n_tail;
            r_ftop <= n_ftop; r_cur <= n_cur; r_round <= n_round; r_ptr <= n_ptr;
            r_ov <= n_ov; r_dispatch <= n_dispatch; r_fq <= n_fq;
        end
        r_kind <= n_kind; r_s <= n_s; r_s_ok <= n_s_ok; r_pid <= n_pid; r_tq <= n_tq;
        r_up <= n_up; r_un <= n_un; r_sw <= n_sw; r_sout <= n_sout; r_st <= n_st;
        r_tk <= n_tk; r_cnt <= n_cnt; r_ql <= n_ql; r_orun <= n_orun;
        r_osw <= n_osw; r_osout <= n_osout; r_ost <= n_ost; r_otk <= n_otk;
        r_ocnt <= n_ocnt;
    end
endmodule
`default_nettype wire

### test/sched_checker.sv
// checker for the round robin quantum scheduler: watches channels, predicts and compares results
`timescale 1ns / 1ps
module sched_checker
    import rrqs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [3:0]  i_slot,
    input  wire logic [14:0] i_pid,
    input  wire logic [15:0] i_task_quantum,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic        o_switched,
    input  wire logic [3:0]  o_running_slot,
    input  wire logic [3:0]  o_slot_out,
    input  wire logic [1:0]  o_status,
    input  wire logic [31:0] o_ticks_used,
    input  wire logic [31:0] o_switch_count,
    input  wire logic [15:0] o_quantum_left,
    input  wire logic        i_cfg_valid,
    input  wire logic        o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    localparam int NSLOT = 16;
    localparam logic [4:0] NIL = 5'd16;

    typedef struct packed {
        logic        switched;
        logic [3:0]  running_slot;
        logic [3:0]  slot_out;
        logic [1:0]  status;
        logic [31:0] ticks_used;
        logic [31:0] switch_count;
        logic [15:0] quantum_left;
    } sched_result_t;

    sched_result_t expected_results[$];

    logic [4:0]  link_next [NSLOT];
    logic [4:0]  link_prev [NSLOT];
    logic [4:0]  list_front;
    logic [4:0]  list_tail;
    logic [4:0]  free_next [NSLOT];
    logic [4:0]  free_head;
    logic [3:0]  cur_slot;
    logic [15:0] round_cnt;
    logic [14:0] pid_tab [NSLOT];
    logic [15:0] quant_tab [NSLOT];
    logic [31:0] tick_tab [NSLOT];
    logic [31:0] disp_tab [NSLOT];
    logic [15:0] left_tab [NSLOT];
    logic [1:0]  mode_tab [NSLOT];
    int          mismatches;

    function automatic logic [15:0] at_least_one(input logic [15:0] q);
        return (q == 16'd0) ? 16'd1 : q;
    endfunction

    function automatic bit is_queued(input int s);
        return mode_tab[s] == M_READY || mode_tab[s] == M_RUN;
    endfunction

    function automatic void unlink_slot(input int s);
        logic [4:0] p;
        logic [4:0] n;
        p = link_prev[s];
        n = link_next[s];
        if (p == NIL) list_front = n; else link_next[p] = n;
        if (n == NIL) list_tail = p; else link_prev[n] = p;
        link_prev[s] = NIL;
        link_next[s] = NIL;
    endfunction

    function automatic void append_slot(input int s);
        link_prev[s] = list_tail;
        link_next[s] = NIL;
        if (list_tail == NIL) list_front = 5'(s); else link_next[list_tail] = 5'(s);
        list_tail = 5'(s);
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < NSLOT; i++) begin
            link_next[i] = NIL;
            link_prev[i] = NIL;
            free_next[i] = (i <= 1) ? NIL : 5'(i - 1);
            pid_tab[i] = '0;
            quant_tab[i] = '0;
            tick_tab[i] = '0;
            disp_tab[i] = '0;
            left_tab[i] = '0;
            mode_tab[i] = M_FREE;
        end
        list_front = '0;
        list_tail = '0;
        free_head = 5'(NSLOT - 1);
        cur_slot = '0;
        quant_tab[0] = FIRST_Q_RESET;
        left_tab[0] = FIRST_Q_RESET;
        mode_tab[0] = M_RUN;
        round_cnt = FIRST_Q_RESET;
    endfunction

    function automatic bit advance_tick();
        int c;
        int h;
        c = cur_slot;
        if (round_cnt != 0) round_cnt--;
        tick_tab[c]++;
        if (left_tab[c] != 0) left_tab[c]--;
        if (round_cnt != 0) return 1'b0;
        if (is_queued(c)) begin
            unlink_slot(c);
            append_slot(c);
            mode_tab[c] = M_READY;
        end
        if (list_front == NIL) begin
            round_cnt = at_least_one(quant_tab[c]);
            return 1'b0;
        end
        h = list_front;
        round_cnt = at_least_one(quant_tab[h]);
        disp_tab[h]++;
        left_tab[h] = round_cnt;
        mode_tab[h] = M_RUN;
        cur_slot = 4'(h);
        return 1'b1;
    endfunction

    function automatic sched_result_t schedule_event(input logic [2:0] kind, input logic [3:0] s,
                                                     input logic [14:0] pid,
                                                     input logic [15:0] q);
        sched_result_t r;
        int i;
        bit live;
        r = '0;
        live = mode_tab[s] != M_FREE;
        case (kind)
            K_TICK: r.switched = advance_tick();
            K_ALLOC: begin
                if (free_head == NIL) begin
                    r.status = ST_NO_FREE;
                end else begin
                    i = free_head;
                    free_head = free_next[i];
                    free_next[i] = NIL;
                    pid_tab[i] = pid;
                    quant_tab[i] = at_least_one(q);
                    tick_tab[i] = '0;
                    disp_tab[i] = '0;
                    left_tab[i] = quant_tab[i];
                    mode_tab[i] = M_READY;
                    append_slot(i);
                    r.slot_out = 4'(i);
                end
            end
            K_RELEASE: begin
                if (!live) begin
                    r.status = ST_NOT_LIVE;
                end else begin
                    if (is_queued(s)) unlink_slot(s);
                    pid_tab[s] = '0;
                    mode_tab[s] = M_FREE;
                    free_next[s] = free_head;
                    free_head = {1'b0, s};
                end
            end
            K_BLOCK: begin
                if (!live) r.status = ST_NOT_LIVE;
                else if (is_queued(s)) begin
                    unlink_slot(s);
                    mode_tab[s] = M_BLOCK;
                end
            end
            K_UNBLOCK: begin
                if (!live) r.status = ST_NOT_LIVE;
                else if (mode_tab[s] == M_BLOCK) begin
                    append_slot(s);
                    mode_tab[s] = M_READY;
                end
            end
            K_FIND: begin
                r.status = ST_NO_PID;
                for (i = 0; i < NSLOT; i++) begin
                    if (r.status == ST_NO_PID && mode_tab[i] != M_FREE && pid_tab[i] == pid) begin
                        r.status = ST_OK;
                        r.slot_out = 4'(i);
                        r.ticks_used = tick_tab[i];
                        r.switch_count = disp_tab[i];
                    end
                end
            end
            default: ;
        endcase
        r.running_slot = cur_slot;
        r.quantum_left = left_tab[cur_slot];
        return r;
    endfunction

    initial begin
        clear_model();
        mismatches = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        sched_result_t got;
        sched_result_t want;
        if (!i_rst_n) begin
            clear_model();
            expected_results.delete();
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_switched, o_running_slot, o_slot_out, o_status,
                        o_ticks_used, o_switch_count, o_quantum_left};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: expected sw %0d run %0d out %0d st %0d",
                                     want.switched, want.running_slot, want.slot_out,
                                     want.status);
                            $display("    tk %0d cnt %0d ql %0d",
                                     want.ticks_used, want.switch_count, want.quantum_left);
                            $display("  got sw %0d run %0d out %0d st %0d",
                                     got.switched, got.running_slot, got.slot_out,
                                     got.status);
                            $display("    tk %0d cnt %0d ql %0d",
                                     got.ticks_used, got.switch_count, got.quantum_left);
                        end
                    end
                end
            end
            if (i_valid && !o_stall)
                expected_results.push_back(schedule_event(i_kind, i_slot, i_pid,
                                                          i_task_quantum));
            if (i_cfg_valid && o_cfg_ready) begin
                quant_tab[0] = at_least_one(i_cfg_data);
                if (cur_slot == 0) begin
                    round_cnt = quant_tab[0];
                    left_tab[0] = quant_tab[0];
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending <= expected_results.size();
    end
endmodule

### test/tb_top.sv
// testbench top for the round robin quantum scheduler: clock, reset, requests, verdict
`timescale 1ns / 1ps
module tb_top
    import rrqs_pkg::*;
();

    localparam logic [2:0] K_SPARE6 = 3'd6;
    localparam logic [2:0] K_SPARE7 = 3'd7;
    localparam int PHASE_ITEMS = 325;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_kind = '0;
    logic [3:0]  i_slot = '0;
    logic [14:0] i_pid = '0;
    logic [15:0] i_task_quantum = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_switched;
    logic [3:0]  o_running_slot;
    logic [3:0]  o_slot_out;
    logic [1:0]  o_status;
    logic [31:0] o_ticks_used;
    logic [31:0] o_switch_count;
    logic [15:0] o_quantum_left;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;
    bit          busy_sender = 1'b0;
    bit          busy_receiver = 1'b0;

    always #1 i_clk = ~i_clk;

    round_robin_quantum_scheduler u_dut (.*);

    sched_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .i_slot, .i_pid, .i_task_quantum,
        .o_valid, .i_stall, .o_switched, .o_running_slot, .o_slot_out, .o_status,
        .o_ticks_used, .o_switch_count, .o_quantum_left, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge i_clk) begin
        i_stall <= !busy_receiver && ($urandom_range(99) < 33);
    end

    task automatic send_request(input logic [2:0] kind, input logic [3:0] s,
                                input logic [14:0] pid, input logic [15:0] q);
        while (!busy_sender && $urandom_range(99) < 33) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_kind = kind;
        i_slot = s;
        i_pid = pid;
        i_task_quantum = q;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_first_quantum(input logic [15:0] value);
        drain_results();
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_request();
        int pick;
        logic [2:0] kind;
        logic [14:0] pid;
        logic [15:0] q;
        pick = $urandom_range(99);
        if (pick < 40) kind = K_TICK;
        else if (pick < 55) kind = K_ALLOC;
        else if (pick < 67) kind = K_RELEASE;
        else if (pick < 77) kind = K_BLOCK;
        else if (pick < 87) kind = K_UNBLOCK;
        else if (pick < 97) kind = K_FIND;
        else kind = pick[0] ? K_SPARE7 : K_SPARE6;
        pid = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(7));
        q = ($urandom_range(49) == 0) ? 16'($urandom) : 16'($urandom_range(5));
        send_request(kind, 4'($urandom), pid, q);
    endtask

    initial begin
        logic [15:0] phase_cfg [4];
        phase_cfg = '{16'hffff, 16'd3, 16'd0, 16'($urandom)};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        write_first_quantum(16'd1);

        send_request(K_ALLOC, 4'd0, 15'h7fff, 16'd0);
        send_request(K_ALLOC, 4'd0, 15'd0, 16'hffff);
        send_request(K_FIND, 4'd0, 15'h7fff, 16'd0);
        send_request(K_FIND, 4'd0, 15'h5555, 16'd0);
        send_request(K_RELEASE, 4'd14, 15'd0, 16'd0);
        send_request(K_BLOCK, 4'd15, 15'd0, 16'd0);
        send_request(K_BLOCK, 4'd15, 15'd0, 16'd0);
        send_request(K_UNBLOCK, 4'd15, 15'd0, 16'd0);
        send_request(K_UNBLOCK, 4'd15, 15'd0, 16'd0);
        send_request(K_RELEASE, 4'd3, 15'd0, 16'd0);
        send_request(K_BLOCK, 4'd3, 15'd0, 16'd0);
        send_request(K_UNBLOCK, 4'd3, 15'd0, 16'd0);
        send_request(K_SPARE6, 4'd0, 15'd0, 16'd0);
        send_request(K_SPARE7, 4'hf, 15'h7fff, 16'hffff);
        send_request(K_BLOCK, 4'd0, 15'd0, 16'd0);
        for (int i = 0; i < 6; i++) send_request(K_TICK, 4'd0, 15'd0, 16'd0);
        send_request(K_UNBLOCK, 4'd0, 15'd0, 16'd0);
        send_request(K_FIND, 4'd0, 15'd0, 16'd0);

        for (int ph = 0; ph < 4; ph++) begin
            write_first_quantum(phase_cfg[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                busy_sender = (ph == 1 && n < 150);
                busy_receiver = (ph == 1 && n < 150);
                if (ph == 2 && n == PHASE_ITEMS / 2) drain_results();
                random_request();
            end
        end
        busy_sender = 1'b0;
        busy_receiver = 1'b0;
        drain_results();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
